@@ rtl/core/scc_pkg.sv @@
// Package for the secret code checker: per-code state and result word types,
// the fixed XOR deciphering table and the length constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

  localparam int unsigned SymW     = 6;
  localparam int unsigned CountW   = 5;
  localparam int unsigned SumW     = 4;
  localparam int unsigned HeaderW  = 24;
  localparam int unsigned KindW    = 2;
  localparam int unsigned IdW      = 15;
  localparam int unsigned TableLen = 48;

  localparam logic [CountW-1:0] COUNT_MAX = 5'd31;
  localparam logic [CountW-1:0] LEN_SHORT = 5'd5;
  localparam logic [CountW-1:0] LEN_MID   = 5'd15;
  localparam logic [CountW-1:0] LEN_LONG  = 5'd20;

  // Deciphering table, indexed by table offset plus symbol position
  localparam logic [SymW-1:0] XOR_TABLE [TableLen] = '{
    6'h15, 6'h23, 6'h2E, 6'h04, 6'h0D, 6'h3F, 6'h1A, 6'h10,
    6'h3A, 6'h2F, 6'h1E, 6'h20, 6'h0F, 6'h3E, 6'h36, 6'h37,
    6'h09, 6'h29, 6'h3B, 6'h31, 6'h02, 6'h16, 6'h3D, 6'h38,
    6'h28, 6'h13, 6'h34, 6'h32, 6'h01, 6'h0B, 6'h0A, 6'h35,
    6'h0E, 6'h1B, 6'h12, 6'h2C, 6'h21, 6'h2D, 6'h25, 6'h30,
    6'h19, 6'h2A, 6'h06, 6'h39, 6'h3C, 6'h17, 6'h33, 6'h18
  };

  // State carried from one symbol of a code to the next
  typedef struct packed {
    logic [2:0]         offset_sel;  // table offset divided by four
    logic [CountW-1:0]  count;
    logic [SumW-1:0]    sum;
    logic [HeaderW-1:0] header;
  } scc_state_t;

  // One result word
  typedef struct packed {
    logic             code_ok;
    logic [KindW-1:0] code_kind;
    logic [IdW-1:0]   owner_id;
  } scc_result_t;

  // Table lookup; positions past the end of the table read as zero
  function automatic logic [SymW-1:0] xor_entry(input logic [SymW-1:0] idx);
    logic [SymW-1:0] val;
    val = '0;
    if (idx < SymW'(TableLen)) begin
      val = XOR_TABLE[idx];
    end
    return val;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/scc_decipher.sv @@
// Decipher step for one symbol: table XOR, running checksum, header capture,
// and the result word for a final symbol. Combinational. Uses scc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scc_decipher (
  input  wire logic [5:0]          symbol,
  input  wire scc_pkg::scc_state_t state_cur,
  output scc_pkg::scc_state_t      state_nxt,
  output scc_pkg::scc_result_t     result
);
  import scc_pkg::*;

  logic            first;
  logic [2:0]      off_sel;
  logic [SymW-1:0] tab_idx;
  logic [SymW-1:0] tab_val;
  logic [SymW-1:0] plain;
  logic            len_ok;
  logic            sum_ok;
  logic            ok;

  // Pick the table offset: from the first symbol, else the held one
  assign first   = (state_cur.count == '0);
  assign off_sel = first ? symbol[5:3] : state_cur.offset_sel;
  assign tab_idx = {1'b0, off_sel, 2'b00} + {1'b0, state_cur.count};
  assign tab_val = xor_entry(tab_idx);

  // Decipher: only the low three bits of the first symbol
  assign plain = first ? (symbol ^ {3'b000, tab_val[2:0]}) : (symbol ^ tab_val);

  // Advance the state for a symbol that is not the last
  always_comb begin
    state_nxt            = state_cur;
    state_nxt.offset_sel = off_sel;
    state_nxt.sum        = SumW'(state_cur.sum + plain[3:0]);
    state_nxt.count      = (state_cur.count == COUNT_MAX) ? COUNT_MAX
                                                          : CountW'(state_cur.count + 5'd1);
    unique case (state_cur.count)
      5'd0:    state_nxt.header = state_cur.header | {plain, 18'd0};
      5'd1:    state_nxt.header = state_cur.header | {6'd0, plain, 12'd0};
      5'd2:    state_nxt.header = state_cur.header | {12'd0, plain, 6'd0};
      5'd3:    state_nxt.header = state_cur.header | {18'd0, plain};
      default: state_nxt.header = state_cur.header;
    endcase
  end

  // Check length and checksum; the last symbol's high bits add nothing mod 16
  assign len_ok = (state_nxt.count == LEN_SHORT) || (state_nxt.count == LEN_MID) ||
                  (state_nxt.count == LEN_LONG);
  assign sum_ok = (state_cur.sum == plain[3:0]);
  assign ok     = len_ok && sum_ok;

  // Read type and id LSB-first; a valid code always has its header complete
  always_comb begin
    result           = '0;
    result.code_ok   = ok;
    if (ok) begin
      result.code_kind = {state_cur.header[19], state_cur.header[20]};
      for (int k = 0; k < IdW; k++) begin
        result.owner_id[k] = state_cur.header[18-k];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/secret_code_checker_top.sv @@
// Top level of the secret code checker: per-code state registers, the
// decipher step and a two-word result buffer. Uses scc_pkg, scc_decipher.
//
// One symbol is accepted per clock cycle while in_stall is low. Each symbol
// is deciphered and folded into the code state as it is accepted; a symbol
// marked last yields one result word, registered for the out_ port, and the
// state returns to zero so the next symbol begins a new code. Results sit
// in a two-word buffer, so input keeps flowing while a result waits;
// in_stall rises only when both buffer words are held by out_stall.
`timescale 1ns / 1ps
`default_nettype none

module secret_code_checker_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [5:0]  in_symbol,
  input  wire logic        in_last_symbol,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_code_ok,
  output logic [1:0]       out_code_kind,
  output logic [14:0]      out_owner_id
);
  import scc_pkg::*;

  scc_state_t  state_r;
  scc_state_t  state_nxt;
  scc_result_t res_nxt;
  scc_result_t out_r;
  scc_result_t skid_r;
  logic        out_valid_r;
  logic        skid_valid_r;
  logic        in_acc;
  logic        push;
  logic        out_take;

  scc_decipher u_decipher (
    .symbol    (in_symbol),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign push     = in_acc && in_last_symbol;
  assign out_take = out_valid_r && !out_stall;

  // Hold the code state; clear it after a last symbol
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_acc) begin
      state_r <= in_last_symbol ? '0 : state_nxt;
    end
  end

  // Result buffer: output word plus a skid word behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || out_take) begin
        out_r       <= res_nxt;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res_nxt;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_code_ok   = out_r.code_ok;
  assign out_code_kind = out_r.code_kind;
  assign out_owner_id  = out_r.owner_id;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Testbench for secret_code_checker_top: drives enciphered codes symbol by symbol and
// checks each result word against a built-in decipher and checksum predictor.
// Depends on rtl/core/secret_code_checker_top.sv, scc_decipher.sv and their package.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned IDLE_LIMIT  = 500;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned DRAIN       = 8;

  typedef struct packed {
    logic        ok;
    logic [1:0]  kind;
    logic [14:0] id;
  } code_result_t;

  typedef enum logic [1:0] {CK_GOOD, CK_BAD, CK_RANDOM} checksum_mode_t;

  // Fixed deciphering table; positions past the end read as zero
  localparam logic [5:0] CIPHER [48] = '{
    6'h15, 6'h23, 6'h2E, 6'h04, 6'h0D, 6'h3F, 6'h1A, 6'h10,
    6'h3A, 6'h2F, 6'h1E, 6'h20, 6'h0F, 6'h3E, 6'h36, 6'h37,
    6'h09, 6'h29, 6'h3B, 6'h31, 6'h02, 6'h16, 6'h3D, 6'h38,
    6'h28, 6'h13, 6'h34, 6'h32, 6'h01, 6'h0B, 6'h0A, 6'h35,
    6'h0E, 6'h1B, 6'h12, 6'h2C, 6'h21, 6'h2D, 6'h25, 6'h30,
    6'h19, 6'h2A, 6'h06, 6'h39, 6'h3C, 6'h17, 6'h33, 6'h18
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [5:0]  in_symbol;
  logic        in_last_symbol;
  logic        out_valid;
  logic        out_stall;
  logic        out_code_ok;
  logic [1:0]  out_code_kind;
  logic [14:0] out_owner_id;

  // Predictor state for the code in progress
  logic [4:0]  code_offset = '0;
  logic [4:0]  code_len    = '0;
  logic [3:0]  code_sum    = '0;
  logic [23:0] code_header = '0;

  code_result_t pending_results[$];

  int  errors         = 0;
  int  words_sent     = 0;
  int  codes_sent     = 0;
  int  results_seen   = 0;
  int  valid_seen     = 0;
  int  idle_cycles    = 0;
  bit  calm           = 1'b0;
  bit  hold_req       = 1'b0;

  secret_code_checker_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_symbol      (in_symbol),
    .in_last_symbol (in_last_symbol),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_ok    (out_code_ok),
    .out_code_kind  (out_code_kind),
    .out_owner_id   (out_owner_id)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [5:0] cipher_at(input logic [5:0] idx);
    return (idx < 6'd48) ? CIPHER[idx] : 6'h00;
  endfunction

  // Advance the predictor by one symbol; return 1 when the symbol closes a code
  function automatic bit decode_symbol(input logic [5:0] sym, input logic last,
                                       output code_result_t res);
    logic [5:0] plain;
    logic       len_ok;
    res = '0;
    if (code_len == 5'd0) begin
      code_offset = {sym[5:3], 2'b00};
      plain = sym ^ (cipher_at({1'b0, code_offset}) & 6'h07);
    end else begin
      plain = sym ^ cipher_at({1'b0, code_offset} + {1'b0, code_len});
    end
    if (code_len < 5'd4) begin
      code_header = code_header | (24'(plain) << (18 - 6 * code_len));
    end
    if (code_len != 5'd31) begin
      code_len = code_len + 5'd1;
    end
    if (!last) begin
      code_sum = code_sum + plain[3:0];
      return 1'b0;
    end
    // The last symbol is not summed; its low nibble is checked against the sum
    len_ok = (code_len == 5'd5) || (code_len == 5'd15) || (code_len == 5'd20);
    res.ok = len_ok && (code_sum == plain[3:0]);
    if (res.ok) begin
      for (int k = 0; k < 2; k++) res.kind[k] = code_header[20 - k];
      for (int k = 0; k < 15; k++) res.id[k] = code_header[18 - k];
    end
    code_offset = '0;
    code_len    = '0;
    code_sum    = '0;
    code_header = '0;
    return 1'b1;
  endfunction

  // Send one word; entered and left at a falling edge
  task automatic send_symbol(input logic [5:0] sym, input logic last);
    code_result_t res;
    if (!calm && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_symbol      <= sym;
    in_last_symbol <= last;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (decode_symbol(sym, last, res)) pending_results.push_back(res);
    @(negedge clk);
  endtask

  // Build and send one code of len symbols from random plaintext
  task automatic send_code(input int len, input checksum_mode_t mode);
    logic [5:0] first;
    logic [5:0] plain;
    logic [5:0] pos;
    logic [4:0] offset;
    logic [3:0] acc;
    first = 6'($urandom);
    codes_sent++;
    if (len == 1) begin
      send_symbol(first, 1'b1);
      return;
    end
    offset = {first[5:3], 2'b00};
    plain  = first ^ (cipher_at({1'b0, offset}) & 6'h07);
    acc    = plain[3:0];
    send_symbol(first, 1'b0);
    for (int i = 1; i < len; i++) begin
      plain = 6'($urandom);
      if (i == len - 1) begin
        if (mode == CK_GOOD) plain[3:0] = acc;
        else if (mode == CK_BAD) plain[3:0] = acc + 4'd1 + 4'($urandom_range(0, 14));
      end else begin
        acc = acc + plain[3:0];
      end
      // the position count saturates, so the table index stops advancing
      pos = {1'b0, offset} + 6'((i < 31) ? i : 31);
      send_symbol(plain ^ cipher_at(pos), i == len - 1);
    end
  endtask

  function automatic int good_length();
    case ($urandom_range(0, 2))
      0:       return 5;
      1:       return 15;
      default: return 20;
    endcase
  endfunction

  task automatic test_single_symbol();
    codes_sent += 2;
    send_symbol(6'h3F, 1'b1);
    send_symbol(6'h00, 1'b1);
  endtask

  task automatic test_short_code();
    send_code(5, CK_GOOD);
  endtask

  task automatic test_bad_checksum();
    send_code(5, CK_BAD);
  endtask

  task automatic test_wrong_length();
    send_code(4, CK_GOOD);
    send_code(6, CK_GOOD);
  endtask

  // Mostly well-formed codes, with wrong lengths, overlong codes, bad checksums and noise mixed in
  task automatic test_random_codes(input int n_words);
    int start;
    int pick;
    start = words_sent;
    while (words_sent - start < n_words) begin
      calm = (words_sent - start >= 200) && (words_sent - start < 350);
      pick = $urandom_range(0, 99);
      if (pick < 60) send_code(good_length(), CK_GOOD);
      else if (pick < 72) send_code($urandom_range(1, 25), CK_GOOD);
      else if (pick < 78) begin
        case ($urandom_range(0, 3))
          0:       send_code(37, CK_GOOD);
          1:       send_code(47, CK_GOOD);
          2:       send_code(52, CK_GOOD);
          default: send_code($urandom_range(32, 60), CK_RANDOM);
        endcase
      end
      else if (pick < 88) send_code(good_length(), CK_BAD);
      else send_code($urandom_range(1, 20), CK_RANDOM);
    end
    calm = 1'b0;
  endtask

  // Hold the result side off while short codes keep coming, so the input stalls
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      if (i % 2 == 0) send_code(1, CK_RANDOM);
      else send_code(5, CK_GOOD);
    end
  endtask

  // Receiver: random stalls, a long hold on request, none while calm
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 22);
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    code_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_code_ok) valid_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual ok=%0b kind=%0d id=%h",
                 $time, out_code_ok, out_code_kind, out_owner_id);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_code_ok !== want.ok) begin
          $display("%0t: code_ok expected %0b actual %0b", $time, want.ok, out_code_ok);
          errors++;
        end
        if (out_code_kind !== want.kind) begin
          $display("%0t: code_kind expected %0d actual %0d", $time, want.kind,
                   out_code_kind);
          errors++;
        end
        if (out_owner_id !== want.id) begin
          $display("%0t: owner_id expected %h actual %h", $time, want.id, out_owner_id);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, pending_results.size());
        $display("secret_code_checker_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    in_valid       = 1'b0;
    in_symbol      = '0;
    in_last_symbol = 1'b0;
    rst_n          = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_single_symbol();
    test_short_code();
    test_bad_checksum();
    test_wrong_length();
    test_backpressure();
    test_random_codes(540);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d symbols in %0d codes, including wrong lengths, overlong codes,",
             words_sent, codes_sent);
    $display("bad checksums and a long output hold; %0d results checked, %0d valid.",
             results_seen, valid_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("secret_code_checker_top verification clean");
    end else begin
      $display("secret_code_checker_top verification failed");
    end
    $finish;
  end

endmodule
